[rtl/multi_servo_slew_limiter_macros.svh]
// Assertion macros used by the servo slew limiter checker.
`ifndef MULTI_SERVO_SLEW_LIMITER_MACROS_SVH
`define MULTI_SERVO_SLEW_LIMITER_MACROS_SVH

// Property that holds in the same cycle, sampled on clk, off during rst.
`define MSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle, consequent in the following cycle.
`define MSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/msl_pkg.sv]
// Shared constants, codes and types of the servo slew limiter.
package msl_pkg;

  // Configuration defaults and fixed widths
  localparam int CHANNELS_DEFAULT = 6;
  localparam int HOME_DEFAULT     = 90;
  localparam int ANGLE_SLOTS      = 6;
  localparam int IDX_W            = 3;
  localparam int LIMIT_W          = 48;
  localparam int INTERVAL_W       = 10;

  localparam logic [INTERVAL_W-1:0] ELAPSED_MAX    = 10'd1023;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd20;
  localparam logic [LIMIT_W-1:0]    UPPER_RESET    = 48'hB4B4_B4B4_B4B4;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_HOME  = 2'd2;
  localparam logic [1:0] KIND_ESTOP = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_LOWER    = 2'd0;
  localparam logic [1:0] REG_UPPER    = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  // Per-item command applied to every channel during the sweep
  typedef struct packed {
    logic               step;     // tick reached the step interval
    logic               set_en;   // set target on channel ch
    logic               home_en;  // all targets go home
    logic [IDX_W-1:0]   ch;
    logic signed [15:0] angle;
  } msl_cmd_t;

endpackage

[rtl/multi_servo_slew_limiter.sv]
// Six-channel servo slew limiter: each item (tick, set target, home, stop)
// gives one result with every channel's current angle. For each item the
// channel memory is swept one channel per cycle with read-modify-write
// behind its registered read, and the result is then handed to the output
// register. The next item is taken during that handoff when the output
// register is free. Channel state resets to the home angle through
// per-channel valid bits, so the block is ready right after reset with no
// clearing pass.
module multi_servo_slew_limiter import msl_pkg::*; #(
  parameter int CHANNELS      = CHANNELS_DEFAULT,
  parameter int HOME_POSITION = HOME_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            kind,
  input  logic [2:0]            channel,
  input  logic signed [15:0]    angle,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  accepted,
  output logic                  moving,
  output logic                  stopped,
  output logic [7:0]            angle_zero,
  output logic [7:0]            angle_one,
  output logic [7:0]            angle_two,
  output logic [7:0]            angle_three,
  output logic [7:0]            angle_four,
  output logic [7:0]            angle_five
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = $clog2(CHANNELS + 1);
  localparam logic [SW-1:0] LAST_STEP = SW'(CHANNELS);
  localparam logic [7:0]    HOME_BYTE = 8'(HOME_POSITION);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Configuration registers
  logic [LIMIT_W-1:0]    lower;
  logic [LIMIT_W-1:0]    upper;
  logic [INTERVAL_W-1:0] interval;

  // Control and scalar state
  logic [1:0]            state;
  logic [SW-1:0]         step;
  msl_cmd_t              cmd;
  logic                  acc_q;
  logic                  moving_acc;
  logic                  moved_acc;
  logic [INTERVAL_W-1:0] elapsed;
  logic                  stop_latch;
  logic [CHANNELS-1:0]   valid;
  logic [7:0]            work_ang [CHANNELS];
  logic [7:0]            out_ang  [ANGLE_SLOTS];

  // Memory and datapath signals
  logic [AW-1:0]         proc_idx;
  logic                  proc_act;
  logic [15:0]           rdata;
  logic [15:0]           entry;
  logic [7:0]            lo_b;
  logic [7:0]            hi_b;
  logic [7:0]            cur_next;
  logic [7:0]            tgt_next;
  logic                  moved;
  logic                  out_free;
  logic                  in_xfer;
  logic                  last_proc;
  logic [INTERVAL_W-1:0] elapsed_inc;

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) || ((state == ST_DONE) && out_free));
  assign in_xfer  = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lower    <= '0;
      upper    <= UPPER_RESET;
      interval <= INTERVAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOWER:    lower    <= cfg_data;
        REG_UPPER:    upper    <= cfg_data;
        REG_INTERVAL: interval <= cfg_data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sweep position: read at step, process entry step-1
  assign proc_idx  = AW'(step - SW'(1));
  assign proc_act  = (state == ST_RUN) && (step != '0);
  assign last_proc = (state == ST_RUN) && (step == LAST_STEP);
  assign entry     = valid[proc_idx] ? rdata : {HOME_BYTE, HOME_BYTE};
  assign lo_b      = lower[8*proc_idx +: 8];
  assign hi_b      = upper[8*proc_idx +: 8];

  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 10'd1;

  msl_ram #(
    .WIDTH (16),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (proc_act),
    .waddr (proc_idx),
    .wdata ({tgt_next, cur_next}),
    .raddr (step[AW-1:0]),
    .rdata (rdata)
  );

  msl_update #(
    .HOME_POSITION (HOME_POSITION)
  ) u_update (
    .cmd      (cmd),
    .idx      (IDX_W'(proc_idx)),
    .cur      (entry[7:0]),
    .tgt      (entry[15:8]),
    .lo       (lo_b),
    .hi       (hi_b),
    .cur_next (cur_next),
    .tgt_next (tgt_next),
    .moved    (moved)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          step <= step + SW'(1);
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (in_xfer) begin
            state <= ST_RUN;
            step  <= '0;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item decode, elapsed counter and stop latch
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed    <= '0;
      stop_latch <= 1'b0;
      acc_q      <= 1'b0;
      cmd        <= '0;
    end else if (in_xfer) begin
      cmd.ch    <= channel;
      cmd.angle <= angle;
      case (kind)
        KIND_TICK: begin
          acc_q       <= !stop_latch;
          cmd.step    <= !stop_latch && (elapsed_inc >= interval);
          cmd.set_en  <= 1'b0;
          cmd.home_en <= 1'b0;
          if (!stop_latch) begin
            elapsed <= elapsed_inc;
          end
        end
        KIND_SET: begin
          acc_q       <= !stop_latch && (channel < 3'(CHANNELS));
          cmd.step    <= 1'b0;
          cmd.set_en  <= !stop_latch && (channel < 3'(CHANNELS));
          cmd.home_en <= 1'b0;
        end
        KIND_HOME: begin
          acc_q       <= !stop_latch;
          cmd.step    <= 1'b0;
          cmd.set_en  <= 1'b0;
          cmd.home_en <= !stop_latch;
        end
        default: begin
          acc_q       <= 1'b1;
          stop_latch  <= 1'b1;
          cmd.step    <= 1'b0;
          cmd.set_en  <= 1'b0;
          cmd.home_en <= 1'b0;
        end
      endcase
    end else if (last_proc && cmd.step && (moved_acc || moved)) begin
      elapsed <= '0;
    end
  end

  // Per-channel valid bits: unwritten entries read as home
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (proc_act) begin
      valid[proc_idx] <= 1'b1;
    end
  end

  // Result gathering over the sweep
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      moving_acc <= 1'b0;
      moved_acc  <= 1'b0;
    end else if (proc_act) begin
      moving_acc         <= moving_acc || (cur_next != tgt_next);
      moved_acc          <= moved_acc || moved;
      work_ang[proc_idx] <= cur_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      accepted <= acc_q;
      moving   <= moving_acc;
      stopped  <= stop_latch;
    end
  end

  for (genvar i = 0; i < ANGLE_SLOTS; i++) begin : g_out
    if (i < CHANNELS) begin : g_used
      always_ff @(posedge clk) begin
        if ((state == ST_DONE) && out_free) begin
          out_ang[i] <= work_ang[i];
        end
      end
    end else begin : g_unused
      assign out_ang[i] = 8'd0;
    end
  end

  assign angle_zero  = out_ang[0];
  assign angle_one   = out_ang[1];
  assign angle_two   = out_ang[2];
  assign angle_three = out_ang[3];
  assign angle_four  = out_ang[4];
  assign angle_five  = out_ang[5];

endmodule

[rtl/msl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
module msl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 6
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/msl_update.sv]
// Per-channel datapath: target clamping and one-degree slew step.
module msl_update import msl_pkg::*; #(
  parameter int HOME_POSITION = HOME_DEFAULT
) (
  input  msl_cmd_t         cmd,
  input  logic [IDX_W-1:0] idx,
  input  logic [7:0]       cur,
  input  logic [7:0]       tgt,
  input  logic [7:0]       lo,
  input  logic [7:0]       hi,
  output logic [7:0]       cur_next,
  output logic [7:0]       tgt_next,
  output logic             moved
);

  localparam logic signed [15:0] HOME_REQ = 16'(HOME_POSITION);

  // Below lo gives lo, otherwise above hi gives hi (lo is checked first when the limits cross)
  function automatic logic [7:0] clamp(input logic signed [15:0] a,
                                       input logic [7:0] lo_v,
                                       input logic [7:0] hi_v);
    logic signed [16:0] a_x;
    logic [7:0]         res;
    a_x = 17'(a);
    if (a_x < $signed({9'd0, lo_v})) begin
      res = lo_v;
    end else if (a_x > $signed({9'd0, hi_v})) begin
      res = hi_v;
    end else begin
      res = a[7:0];
    end
    return res;
  endfunction

  // Target update
  always_comb begin
    tgt_next = tgt;
    if (cmd.home_en) begin
      tgt_next = clamp(HOME_REQ, lo, hi);
    end
    if (cmd.set_en && (idx == cmd.ch)) begin
      tgt_next = clamp(cmd.angle, lo, hi);
    end
  end

  // Slew one degree toward target on a step tick
  always_comb begin
    moved    = cmd.step && (cur != tgt);
    cur_next = cur;
    if (moved) begin
      cur_next = (cur < tgt) ? cur + 8'd1 : cur - 8'd1;
    end
  end

endmodule

[rtl/msl_checker.sv]
// Port-level checker for the servo slew limiter, bound to the top level.
`include "multi_servo_slew_limiter_macros.svh"

module msl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       accepted,
  input logic       moving,
  input logic       stopped,
  input logic [7:0] angle_zero,
  input logic [7:0] angle_one,
  input logic [7:0] angle_two,
  input logic [7:0] angle_three,
  input logic [7:0] angle_four,
  input logic [7:0] angle_five
);

  // Whole result payload
  logic [50:0] result;
  assign result = {accepted, moving, stopped, angle_five, angle_four, angle_three,
                   angle_two, angle_one, angle_zero};

  // An accepted item keeps the input side busy at the start of the channel sweep
  `MSL_ASSERT_NEXT(a_busy_after_xfer, in_valid && !in_stall, in_stall ##1 in_stall, "input taken during sweep")

  // A stopped result is never followed by a non-stopped one
  `MSL_ASSERT_NEXT(a_stop_sticky, out_valid && stopped, !out_valid || stopped, "stop latch cleared")

  // A valid result carries no unknown bits
  `MSL_ASSERT(a_out_known, !out_valid || !$isunknown(result), "result has unknown bits")

  // A stalled result holds
  `MSL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result), "stalled result changed")

endmodule

bind multi_servo_slew_limiter msl_checker u_msl_checker (.*);
